// File: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define CHK_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/s2lab_pkg.sv
package s2lab_pkg;

    localparam int CHAN_W   = 8;
    localparam int LIN_W    = 17;
    localparam int COEF_W   = 16;
    localparam int XYZ_W    = 17;
    localparam int F_W      = 17;
    localparam int L_W      = 15;
    localparam int AB_W     = 16;

    // matrix rows, each already divided by the white point
    localparam logic [COEF_W-1:0] KXR = 16'd28439;
    localparam logic [COEF_W-1:0] KXG = 16'd24655;
    localparam logic [COEF_W-1:0] KXB = 16'd12442;
    localparam logic [COEF_W-1:0] KYR = 16'd13938;
    localparam logic [COEF_W-1:0] KYG = 16'd46868;
    localparam logic [COEF_W-1:0] KYB = 16'd4730;
    localparam logic [COEF_W-1:0] KZR = 16'd1164;
    localparam logic [COEF_W-1:0] KZG = 16'd7174;
    localparam logic [COEF_W-1:0] KZB = 16'd57198;

    // linear part of f(): x*24389 <= 216*65536 holds up to this x
    localparam logic [XYZ_W-1:0] LIN_X_MAX = 17'd580;
    localparam logic [30:0] LIN_SLOPE  = 31'd903292;
    localparam logic [30:0] LIN_OFFSET = 31'd1048634000;
    localparam int          RECIP_SH   = 48;
    localparam longint unsigned LIN_RECIP =
        ((64'd1 << RECIP_SH) + 64'd115999) / 64'd116000;

    // cube root: one radicand digit of three bits per stage
    localparam int CBRT_STEPS = 18;
    localparam int RAD_W      = 3 * CBRT_STEPS;
    localparam int ROOT_W     = 18;
    localparam int SQ_W       = 36;
    localparam int REM_W      = 42;

    localparam logic [L_W-1:0] L_MAX = 15'd25600;

    function automatic longint unsigned q30_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic longint unsigned q30_pow5(input longint unsigned r);
        longint unsigned r2;
        longint unsigned r4;
        r2 = q30_mul(r, r);
        r4 = q30_mul(r2, r2);
        return q30_mul(r4, r);
    endfunction

    // sRGB decoding curve to Q16, evaluated at elaboration to fill the table
    function automatic logic [LIN_W-1:0] lin_value(input int unsigned code);
        longint unsigned c;
        longint unsigned t30;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned lin30;
        c = longint'(code) & 64'hFF;
        if (c <= 64'd10)
        begin
            return LIN_W'((c * 64'd6553600 + 64'd164730) / 64'd329460);
        end
        t30 = ((64'd1000 * c + 64'd14025) * (64'd1 << 30) + 64'd134512) / 64'd269025;
        s   = (t30 * t30 + (64'd1 << 29)) >> 30;
        lo  = 64'd0;
        hi  = 64'd1 << 30;
        while (lo < hi)
        begin
            mid = (lo + hi + 64'd1) >> 1;
            if (q30_pow5(mid) <= s)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 64'd1;
            end
        end
        lin30 = (s * lo + (64'd1 << 29)) >> 30;
        return LIN_W'((lin30 + (64'd1 << 13)) >> 14);
    endfunction

endpackage

// File: hdl/s2lab_pix_if.sv
interface s2lab_pix_if;
    import s2lab_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: hdl/s2lab_lab_if.sv
interface s2lab_lab_if;
    import s2lab_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [L_W-1:0]         lightness;
    logic signed [AB_W-1:0] green_red_axis;
    logic signed [AB_W-1:0] blue_yellow_axis;
    modport source (output valid, output lightness, output green_red_axis,
                    output blue_yellow_axis, input ready);
    modport sink (input valid, input lightness, input green_red_axis,
                  input blue_yellow_axis, output ready);
endinterface

// File: hdl/s2lab_lut.sv
module s2lab_lut (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [s2lab_pkg::CHAN_W-1:0] red,
    input  logic [s2lab_pkg::CHAN_W-1:0] green,
    input  logic [s2lab_pkg::CHAN_W-1:0] blue,
    output logic                        out_valid,
    output logic [s2lab_pkg::LIN_W-1:0]  lin_r,
    output logic [s2lab_pkg::LIN_W-1:0]  lin_g,
    output logic [s2lab_pkg::LIN_W-1:0]  lin_b
);
    import s2lab_pkg::*;

    logic [LIN_W-1:0] rom [256];
    logic             valid_reg;
    logic [LIN_W-1:0] r_reg;
    logic [LIN_W-1:0] g_reg;
    logic [LIN_W-1:0] b_reg;

    for (genvar i = 0; i < 256; i++)
    begin : g_rom
        assign rom[i] = lin_value(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg <= rom[red];
            g_reg <= rom[green];
            b_reg <= rom[blue];
        end
    end

    assign out_valid = valid_reg;
    assign lin_r     = r_reg;
    assign lin_g     = g_reg;
    assign lin_b     = b_reg;
endmodule

// File: hdl/s2lab_mat.sv
module s2lab_mat (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [s2lab_pkg::LIN_W-1:0]  lin_r,
    input  logic [s2lab_pkg::LIN_W-1:0]  lin_g,
    input  logic [s2lab_pkg::LIN_W-1:0]  lin_b,
    output logic                        out_valid,
    output logic [s2lab_pkg::XYZ_W-1:0]  x,
    output logic [s2lab_pkg::XYZ_W-1:0]  y,
    output logic [s2lab_pkg::XYZ_W-1:0]  z
);
    import s2lab_pkg::*;

    localparam int P_W = LIN_W + COEF_W;
    localparam int S_W = P_W + 1;

    logic [P_W-1:0]   prod_reg [9];
    logic [P_W-1:0]   prod_next [9];
    logic [XYZ_W-1:0] x_reg, y_reg, z_reg;
    logic [S_W-1:0]   sx, sy, sz;
    logic [1:0]       valid_reg;

    always_comb
    begin
        prod_next[0] = P_W'(lin_r) * P_W'(KXR);
        prod_next[1] = P_W'(lin_g) * P_W'(KXG);
        prod_next[2] = P_W'(lin_b) * P_W'(KXB);
        prod_next[3] = P_W'(lin_r) * P_W'(KYR);
        prod_next[4] = P_W'(lin_g) * P_W'(KYG);
        prod_next[5] = P_W'(lin_b) * P_W'(KYB);
        prod_next[6] = P_W'(lin_r) * P_W'(KZR);
        prod_next[7] = P_W'(lin_g) * P_W'(KZG);
        prod_next[8] = P_W'(lin_b) * P_W'(KZB);
    end

    // row sums with rounding back to Q16
    assign sx = S_W'(prod_reg[0]) + S_W'(prod_reg[1]) + S_W'(prod_reg[2]) + S_W'(32768);
    assign sy = S_W'(prod_reg[3]) + S_W'(prod_reg[4]) + S_W'(prod_reg[5]) + S_W'(32768);
    assign sz = S_W'(prod_reg[6]) + S_W'(prod_reg[7]) + S_W'(prod_reg[8]) + S_W'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 2'b00;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            x_reg <= sx[S_W-2 -: XYZ_W];
            y_reg <= sy[S_W-2 -: XYZ_W];
            z_reg <= sz[S_W-2 -: XYZ_W];
        end
    end

    assign out_valid = valid_reg[1];
    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;
endmodule

// File: hdl/s2lab_cie_f.sv
module s2lab_cie_f (
    input  logic                       clk,
    input  logic                       adv,
    input  logic [s2lab_pkg::XYZ_W-1:0] x,
    output logic [s2lab_pkg::F_W-1:0]   f
);
    import s2lab_pkg::*;

    localparam int N = CBRT_STEPS;

    logic [REM_W-1:0]  r_reg   [N];
    logic [ROOT_W-1:0] y_reg   [N];
    logic [SQ_W-1:0]   y2_reg  [N];
    logic [RAD_W-1:0]  rad_reg [N];
    logic [30:0]       lin_reg [N];
    logic              sel_reg [N];
    logic [ROOT_W:0]   y_up;

    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic [REM_W-1:0]  r_in;
        logic [ROOT_W-1:0] y_in;
        logic [SQ_W-1:0]   y2_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rs;
        logic [ROOT_W-1:0] ys;
        logic [SQ_W-1:0]   y2s;
        logic [REM_W-1:0]  t;
        logic              take;
        logic [30:0]       lin_next;
        logic              sel_next;

        if (s == 0)
        begin : g_first
            // radicand is 8 * x * 2^32 so one extra digit gives the rounding bit
            assign rad_in   = RAD_W'({x, 35'd0});
            assign r_in     = '0;
            assign y_in     = '0;
            assign y2_in    = '0;
            assign lin_next = 31'(x[9:0]) * LIN_SLOPE + LIN_OFFSET;
            assign sel_next = (x <= LIN_X_MAX);
        end
        else
        begin : g_rest
            assign rad_in   = rad_reg[s-1];
            assign r_in     = r_reg[s-1];
            assign y_in     = y_reg[s-1];
            assign y2_in    = y2_reg[s-1];
            assign sel_next = sel_reg[s-1];
            if (s == 1)
            begin : g_div
                logic [62:0] lin_prod;
                // divide by 116000 through the reciprocal
                assign lin_prod = 63'(lin_reg[s-1]) * 63'(LIN_RECIP);
                assign lin_next = 31'(lin_prod >> RECIP_SH);
            end
            else
            begin : g_copy
                assign lin_next = lin_reg[s-1];
            end
        end

        assign ys   = {y_in[ROOT_W-2:0], 1'b0};
        assign y2s  = {y2_in[SQ_W-3:0], 2'b00};
        assign rs   = {r_in[REM_W-4:0], rad_in[RAD_W-1-3*s -: 3]};
        assign t    = REM_W'(y2s) + REM_W'({y2s, 1'b0}) + REM_W'(ys)
                    + REM_W'({ys, 1'b0}) + REM_W'(1);
        assign take = (rs >= t);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[s] <= rad_in;
                lin_reg[s] <= lin_next;
                sel_reg[s] <= sel_next;
                if (take)
                begin
                    r_reg[s]  <= rs - t;
                    y_reg[s]  <= ys + ROOT_W'(1);
                    y2_reg[s] <= y2s + SQ_W'({ys, 1'b0}) + SQ_W'(1);
                end
                else
                begin
                    r_reg[s]  <= rs;
                    y_reg[s]  <= ys;
                    y2_reg[s] <= y2s;
                end
            end
        end
    end

    // floor(cbrt(8n)) is 2y or 2y+1, halving it rounded up gives round(cbrt(n))
    assign y_up = {1'b0, y_reg[N-1]} + (ROOT_W+1)'(1);
    assign f    = sel_reg[N-1] ? F_W'(lin_reg[N-1]) : y_up[F_W:1];
endmodule

// File: hdl/srgb_to_cielab_converter_top.sv
// sRGB to CIE L*a*b* (D65) converter
// pixel channel: one request carries red, green and blue, 8 bits each
// lab channel: one request carries lightness (unsigned Q8, 0..100),
//   green_red_axis and blue_yellow_axis (signed Q8, saturated)
// one result per pixel, in order; no configuration
// throughput: one pixel per cycle while no finished result waits on the lab side
// from accepted pixel to valid result a pixel passes the decoding table register,
//   the matrix product and row sum registers, the eighteen cube root stages
//   (one radicand digit per stage) and the output arithmetic register
// the pipeline moves as a whole: pixel.ready is high whenever the output
//   register is empty or being taken
// a stall on the lab side holds every stage, so nothing is lost or repeated;
//   pixel.ready drops only while a finished result waits
// reset empties the pipeline; the first pixel is taken right after it
module srgb_to_cielab_converter_top (
    input  logic              clk,
    input  logic              rst_n,
    s2lab_pix_if.sink         pixel,
    s2lab_lab_if.source       lab
);
    import s2lab_pkg::*;

    localparam int VD = CBRT_STEPS;

    logic             adv;
    logic             v_lut, v_mat;
    logic [LIN_W-1:0] lin_r, lin_g, lin_b;
    logic [XYZ_W-1:0] xn, yn, zn;
    logic [F_W-1:0]   fx, fy, fz;
    logic [VD-1:0]    vd_reg;
    logic             out_valid_reg;
    logic [L_W-1:0]   l_reg;
    logic signed [AB_W-1:0] a_reg, b_reg;

    logic signed [24:0] lv;
    logic signed [16:0] lq;
    logic signed [17:0] da, db;
    logic signed [26:0] av, bv;
    logic signed [18:0] aq, bq;
    logic [L_W-1:0]         l_next;
    logic signed [AB_W-1:0] a_next, b_next;

    assign adv         = !out_valid_reg || lab.ready;
    assign pixel.ready = adv;

    s2lab_lut u_lut (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(pixel.valid),
        .red(pixel.red), .green(pixel.green), .blue(pixel.blue),
        .out_valid(v_lut), .lin_r(lin_r), .lin_g(lin_g), .lin_b(lin_b)
    );

    s2lab_mat u_mat (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v_lut),
        .lin_r(lin_r), .lin_g(lin_g), .lin_b(lin_b),
        .out_valid(v_mat), .x(xn), .y(yn), .z(zn)
    );

    s2lab_cie_f u_fx (.clk(clk), .adv(adv), .x(xn), .f(fx));
    s2lab_cie_f u_fy (.clk(clk), .adv(adv), .x(yn), .f(fy));
    s2lab_cie_f u_fz (.clk(clk), .adv(adv), .x(zn), .f(fz));

    always_comb
    begin
        lv = 25'(116) * $signed({8'd0, fy}) - 25'sd1048576;
        lq = 17'((lv + 25'sd128) >>> 8);
        if (lq < 0)
        begin
            l_next = '0;
        end
        else if (lq > $signed({2'b00, L_MAX}))
        begin
            l_next = L_MAX;
        end
        else
        begin
            l_next = lq[L_W-1:0];
        end

        da = $signed({1'b0, fx}) - $signed({1'b0, fy});
        db = $signed({1'b0, fy}) - $signed({1'b0, fz});
        av = 27'sd500 * 27'(da);
        bv = 27'sd200 * 27'(db);
        aq = 19'((av + 27'sd128) >>> 8);
        bq = 19'((bv + 27'sd128) >>> 8);

        if (aq > 19'sd32767)
        begin
            a_next = 16'sh7FFF;
        end
        else if (aq < -19'sd32768)
        begin
            a_next = -16'sh8000;
        end
        else
        begin
            a_next = aq[AB_W-1:0];
        end

        if (bq > 19'sd32767)
        begin
            b_next = 16'sh7FFF;
        end
        else if (bq < -19'sd32768)
        begin
            b_next = -16'sh8000;
        end
        else
        begin
            b_next = bq[AB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vd_reg        <= {vd_reg[VD-2:0], v_mat};
            out_valid_reg <= vd_reg[VD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_reg <= l_next;
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign lab.valid            = out_valid_reg;
    assign lab.lightness        = l_reg;
    assign lab.green_red_axis   = a_reg;
    assign lab.blue_yellow_axis = b_reg;
endmodule

// File: hdl/s2lab_checker.sv
`include "assert_macros.svh"

module s2lab_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [s2lab_pkg::L_W-1:0]      lightness,
    input logic signed [s2lab_pkg::AB_W-1:0] green_red_axis
);
    import s2lab_pkg::*;

    // a waiting result holds its value
    `CHK_CLK(a_hold, out_valid && !out_ready |=> out_valid && $stable(lightness) && $stable(green_red_axis), "result changed while stalled")

    // lightness never leaves 0..100
    `CHK_CLK(a_l_range, out_valid |-> lightness <= L_MAX, "lightness above range")

    // the pipeline stalls as a whole behind a waiting result
    `CHK_CLK(a_stall, out_valid && !out_ready |-> !in_ready, "pixel taken while result waits")

    // an empty output register always takes a pixel
    `CHK_CLK(a_open, !out_valid |-> in_ready, "pixel refused with empty output")
endmodule

bind srgb_to_cielab_converter_top s2lab_checker u_s2lab_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(pixel.ready),
    .out_valid(lab.valid),
    .out_ready(lab.ready),
    .lightness(lab.lightness),
    .green_red_axis(lab.green_red_axis)
);
